// ===== rtl/core/lrt_pkg.sv =====
// Package for the learning route table: field widths, request and action codes,
// and the structs passed between the controller and the chain of table cells.
// No dependencies.
`default_nettype none

package lrt_pkg;

    // Field widths of the stream payloads.
    localparam int REQ_W   = 3;
    localparam int ID_W    = 8;
    localparam int ADDR_W  = 16;
    localparam int SIG_W   = 8;
    localparam int BEST_W  = 9;
    localparam int ORDER_W = 4;
    localparam int AGE_W   = 4;
    localparam int ACT_W   = 3;

    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;

    // Default table depth.
    localparam int ROUTE_ENTRIES_DEF = 32;

    // Configuration register indexes and reset values.
    localparam logic [CFG_ADDR_W-1:0] CFG_OWN_ID         = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INACTIVE_LIMIT = 1'b1;
    localparam logic [ID_W-1:0]       OWN_ID_RST         = 8'd1;
    localparam logic [AGE_W-1:0]      LIMIT_RST          = 4'd4;

    // Best signal after reset or a send timeout lies below any 8-bit signal.
    localparam logic signed [BEST_W-1:0] SIGNAL_FLOOR = 9'sh100;

    // Command order that opens the valve.
    localparam logic [ORDER_W-1:0] ORDER_OPEN = 4'd1;

    typedef enum logic [REQ_W-1:0] {
        REQ_REPORT       = 3'd0,
        REQ_COMMAND      = 3'd1,
        REQ_AGE_TICK     = 3'd2,
        REQ_PARENT_RESP  = 3'd3,
        REQ_ANNOUNCE     = 3'd4,
        REQ_SEND_TIMEOUT = 3'd5
    } req_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE       = 3'd0,
        ACT_FORWARD    = 3'd1,
        ACT_LOCAL      = 3'd2,
        ACT_NO_ROUTE   = 3'd3,
        ACT_TABLE_FULL = 3'd4,
        ACT_ANSWER     = 3'd5
    } act_t;

    // Operation performed by the cells as the walk token passes them.
    typedef enum logic [1:0] {
        OP_IDLE   = 2'd0,
        OP_LEARN  = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_AGE    = 2'd3
    } walk_op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_WALK = 2'd1,
        ST_EMIT = 2'd2
    } ctrl_state_t;

    // Query held steady by the controller for the length of a walk.
    typedef struct packed {
        walk_op_t          op;
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] from_addr;
        logic [AGE_W-1:0]  limit;
    } query_t;

    // Token handed from cell to cell, one cell per cycle.
    typedef struct packed {
        logic              active;
        logic              found;
        logic [ADDR_W-1:0] hop;
        logic              free_seen;
    } token_t;

    // Broadcast at the end of a transaction: installs a new entry in the
    // cell that reserved itself, and clears every reservation.
    typedef struct packed {
        logic              clear;
        logic              write;
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] hop;
    } commit_t;

endpackage

`default_nettype wire

// ===== rtl/core/lrt_cell.sv =====
// One route table entry with its share of the walk token pipeline.
// Depends on lrt_pkg.
`default_nettype none

module lrt_cell (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire lrt_pkg::query_t  query,
    input  wire lrt_pkg::commit_t commit,
    input  wire lrt_pkg::token_t  token_in,
    output lrt_pkg::token_t       token_out,
    output logic                  pend
);
    import lrt_pkg::*;

    logic              valid_reg;
    logic              pend_reg;
    logic [ID_W-1:0]   dest_reg;
    logic [ADDR_W-1:0] hop_reg;
    logic [AGE_W-1:0]  age_reg;
    token_t            token_reg;
    token_t            token_next;

    logic hit;
    logic learn_hit;
    logic reserve;
    logic age_here;
    logic evict;

    // Decode what this cell does while the token sits at its input.
    always_comb begin
        hit       = token_in.active && valid_reg && (dest_reg == query.id) &&
                    ((query.op == OP_LEARN) || (query.op == OP_LOOKUP));
        learn_hit = hit && (query.op == OP_LEARN);
        reserve   = token_in.active && (query.op == OP_LEARN) && !valid_reg &&
                    !token_in.free_seen;
        age_here  = token_in.active && (query.op == OP_AGE) && valid_reg;
        evict     = age_here && (age_reg >= query.limit);
    end

    // Pass the token on, merging in this entry's match and free status.
    always_comb begin
        token_next           = token_in;
        token_next.found     = token_in.found || hit;
        token_next.hop       = hit ? hop_reg : token_in.hop;
        token_next.free_seen = token_in.free_seen || !valid_reg;
    end

    // Control state: entry valid, reservation, and the token register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
            token_reg <= '0;
        end else begin
            token_reg <= token_next;
            if (evict) begin
                valid_reg <= 1'b0;
            end else if (commit.write && pend_reg) begin
                valid_reg <= 1'b1;
            end
            if (commit.clear) begin
                pend_reg <= 1'b0;
            end else if (reserve) begin
                pend_reg <= 1'b1;
            end
        end
    end

    // Entry payload.
    always_ff @(posedge aclk) begin
        if (commit.write && pend_reg) begin
            dest_reg <= commit.id;
            hop_reg  <= commit.hop;
            age_reg  <= '0;
        end else if (learn_hit) begin
            hop_reg <= query.from_addr;
            age_reg <= '0;
        end else if (age_here && !evict) begin
            age_reg <= age_reg + AGE_W'(1);
        end
    end

    assign token_out = token_reg;
    assign pend      = pend_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lrt_ctrl.sv =====
// Controller for the route table: stream handshakes, configuration registers,
// parent and valve state, walk sequencing and the output register.
// Depends on lrt_pkg.
`default_nettype none

module lrt_ctrl (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // s_tdata: node_id[7:0], from_addr[23:8], signal[31:24], order_digit[35:32]
    input  wire logic [lrt_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: req_type[2:0]
    input  wire logic [lrt_pkg::REQ_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // m_tdata: next_hop[15:0], valve_open[16], connected[17], parent_link[33:18]
    output logic [lrt_pkg::M_TDATA_W-1:0]       m_tdata,
    // m_tuser: action[2:0]
    output logic [lrt_pkg::ACT_W-1:0]           m_tuser,
    input  wire logic                           cfg_wr_en,
    input  wire logic [lrt_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [lrt_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output lrt_pkg::query_t                     query,
    output lrt_pkg::commit_t                    commit,
    output lrt_pkg::token_t                     walk_head,
    input  wire lrt_pkg::token_t                chain_end
);
    import lrt_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // Configuration.
    logic [ID_W-1:0]  own_id_reg;
    logic [AGE_W-1:0] limit_reg;

    // Held input transaction.
    req_t               item_req_reg;
    logic [ID_W-1:0]    item_id_reg;
    logic [ADDR_W-1:0]  item_from_reg;
    logic [SIG_W-1:0]   item_sig_reg;
    logic [ORDER_W-1:0] item_order_reg;

    // Walk outcome.
    logic              start_reg;
    logic              found_reg;
    logic              free_reg;
    logic [ADDR_W-1:0] found_hop_reg;

    // Node state.
    logic [ADDR_W-1:0]        parent_reg;
    logic signed [BEST_W-1:0] best_reg;
    logic                     connected_reg;
    logic                     valve_reg;

    // Output register.
    logic              m_valid_reg;
    act_t              out_act_reg;
    logic [ADDR_W-1:0] out_hop_reg;
    logic              out_valve_reg;
    logic              out_conn_reg;
    logic [ADDR_W-1:0] out_parent_reg;

    logic              in_accept;
    logic              needs_walk;
    logic              out_load;
    req_t              in_req;
    logic [ID_W-1:0]   in_id;

    act_t                     res_act;
    logic [ADDR_W-1:0]        res_hop;
    logic                     valve_next;
    logic                     conn_next;
    logic [ADDR_W-1:0]        parent_next;
    logic signed [BEST_W-1:0] best_next;
    logic                     res_install;
    logic signed [BEST_W-1:0] sig_ext;

    // Input decode.
    always_comb begin
        in_req     = req_t'(s_tuser);
        in_id      = s_tdata[ID_W-1:0];
        needs_walk = (in_req == REQ_REPORT) || (in_req == REQ_AGE_TICK) ||
                     ((in_req == REQ_COMMAND) && (in_id != own_id_reg));
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = needs_walk ? ST_WALK : ST_EMIT;
                end
            end
            ST_WALK: begin
                if (chain_end.active) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs and sequencing strobes.
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        in_accept = s_tvalid && s_tready;
        out_load  = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);
    end

    // Query for the cells, built from the held transaction.
    always_comb begin
        case (item_req_reg)
            REQ_REPORT:   query.op = OP_LEARN;
            REQ_COMMAND:  query.op = OP_LOOKUP;
            REQ_AGE_TICK: query.op = OP_AGE;
            default:      query.op = OP_IDLE;
        endcase
        query.id        = item_id_reg;
        query.from_addr = item_from_reg;
        query.limit     = limit_reg;

        walk_head.active    = start_reg;
        walk_head.found     = 1'b0;
        walk_head.hop       = '0;
        walk_head.free_seen = 1'b0;
    end

    // Result of the held transaction and the node state it leaves behind.
    always_comb begin
        res_act     = ACT_NONE;
        res_hop     = '0;
        valve_next  = valve_reg;
        conn_next   = connected_reg;
        parent_next = parent_reg;
        best_next   = best_reg;
        res_install = 1'b0;
        sig_ext     = {item_sig_reg[SIG_W-1], item_sig_reg};
        case (item_req_reg)
            REQ_REPORT: begin
                if (!found_reg && !free_reg) begin
                    res_act = ACT_TABLE_FULL;
                end else begin
                    res_install = !found_reg;
                    if (item_from_reg[7:0] != parent_reg[7:0]) begin
                        res_act = ACT_FORWARD;
                        res_hop = parent_reg;
                    end
                end
            end
            REQ_COMMAND: begin
                if (item_id_reg == own_id_reg) begin
                    valve_next = (item_order_reg == ORDER_OPEN);
                    res_act    = ACT_LOCAL;
                end else if (found_reg) begin
                    res_act = ACT_FORWARD;
                    res_hop = found_hop_reg;
                end else begin
                    res_act = ACT_NO_ROUTE;
                end
            end
            REQ_PARENT_RESP: begin
                if ((item_id_reg == own_id_reg) && (sig_ext > best_reg)) begin
                    best_next   = sig_ext;
                    parent_next = item_from_reg;
                    conn_next   = 1'b1;
                end
            end
            REQ_ANNOUNCE: begin
                if (connected_reg) begin
                    res_act = ACT_ANSWER;
                    res_hop = item_from_reg;
                end
            end
            REQ_SEND_TIMEOUT: begin
                conn_next = 1'b0;
                best_next = SIGNAL_FLOOR;
            end
            default: begin
                res_act = ACT_NONE;
            end
        endcase

        commit.clear = out_load;
        commit.write = out_load && res_install;
        commit.id    = item_id_reg;
        commit.hop   = item_from_reg;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            own_id_reg    <= OWN_ID_RST;
            limit_reg     <= LIMIT_RST;
            parent_reg    <= '0;
            best_reg      <= SIGNAL_FLOOR;
            connected_reg <= 1'b0;
            valve_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= in_accept && needs_walk;
            if (out_load) begin
                m_valid_reg   <= 1'b1;
                parent_reg    <= parent_next;
                best_reg      <= best_next;
                connected_reg <= conn_next;
                valve_reg     <= valve_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_OWN_ID:         own_id_reg <= cfg_wdata;
                    CFG_INACTIVE_LIMIT: limit_reg  <= cfg_wdata[AGE_W-1:0];
                    default:            own_id_reg <= own_id_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            item_req_reg   <= in_req;
            item_id_reg    <= in_id;
            item_from_reg  <= s_tdata[ID_W +: ADDR_W];
            item_sig_reg   <= s_tdata[ID_W+ADDR_W +: SIG_W];
            item_order_reg <= s_tdata[ID_W+ADDR_W+SIG_W +: ORDER_W];
            found_reg      <= 1'b0;
            free_reg       <= 1'b0;
            found_hop_reg  <= '0;
        end else if ((state_reg == ST_WALK) && chain_end.active) begin
            found_reg     <= chain_end.found;
            free_reg      <= chain_end.free_seen;
            found_hop_reg <= chain_end.hop;
        end
        if (out_load) begin
            out_act_reg    <= res_act;
            out_hop_reg    <= res_hop;
            out_valve_reg  <= valve_next;
            out_conn_reg   <= conn_next;
            out_parent_reg <= parent_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_act_reg;
    assign m_tdata  = {(M_TDATA_W - 2*ADDR_W - 2)'(0), out_parent_reg, out_conn_reg,
                       out_valve_reg, out_hop_reg};

`ifndef SYNTHESIS
    // The token leaves the chain only during a walk.
    a_end_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_end.active |-> (state_reg == ST_WALK))
        else $error("walk token left the chain outside a walk");

    // A new entry is installed only when the source was absent and a slot was free.
    a_install_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        commit.write |-> (!found_reg && free_reg))
        else $error("entry installed for a known source or into a full table");

    // Being connected implies a parent signal above the floor.
    a_conn_best: assert property (@(posedge aclk) disable iff (!aresetn)
        connected_reg |-> (best_reg != SIGNAL_FLOOR))
        else $error("connected with no recorded parent signal");

    // An accepted walk transaction starts its token in the next cycle.
    a_walk_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && needs_walk) |=> (start_reg && (state_reg == ST_WALK)))
        else $error("walk did not start after accept");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/learning_route_table_with_aging_unit.sv =====
// Top level of the learning route table with aging and parent selection.
// Depends on lrt_pkg, lrt_cell and lrt_ctrl.
//
// Usage:
//   Requests enter on the s_ stream (s_tuser carries the request type, s_tdata
//   the node id, link address, signal and command order). Each accepted
//   transaction yields exactly one result on the m_ stream (m_tuser carries
//   the action, m_tdata the next hop, valve and connection state and parent).
//   Reports, age ticks and commands for other nodes walk a token down a chain
//   of ROUTE_ENTRIES table cells, one cell per cycle. When the token leaves
//   the chain its outcome is latched, and from the emit state the result is
//   loaded into the output register once that register is free. Other
//   requests go straight to the emit state. One transaction is in flight at a time.
//   The output register holds a finished result while the receiver stalls;
//   the next request is accepted meanwhile, and its result waits for the
//   register to drain.
//   Configuration (own id, inactive limit) is written through cfg_wr_en, cfg_addr
//   and cfg_wdata by the user, only while no transaction is in flight (unchecked).
//   A synchronous active-low reset empties the table, closes the valve,
//   disconnects from the parent and restores the default configuration.
`default_nettype none

module learning_route_table_with_aging_unit #(
    parameter int ROUTE_ENTRIES = lrt_pkg::ROUTE_ENTRIES_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // s_tdata: node_id[7:0], from_addr[23:8], signal[31:24], order_digit[35:32]
    input  wire logic [lrt_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: req_type[2:0]
    input  wire logic [lrt_pkg::REQ_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // m_tdata: next_hop[15:0], valve_open[16], connected[17], parent_link[33:18]
    output logic [lrt_pkg::M_TDATA_W-1:0]       m_tdata,
    // m_tuser: action[2:0]
    output logic [lrt_pkg::ACT_W-1:0]           m_tuser,
    input  wire logic                           cfg_wr_en,
    input  wire logic [lrt_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [lrt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import lrt_pkg::*;

    query_t                   query;
    commit_t                  commit;
    token_t                   chain_tok [0:ROUTE_ENTRIES];
    logic [ROUTE_ENTRIES-1:0] pend_bits;

    lrt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .query     (query),
        .commit    (commit),
        .walk_head (chain_tok[0]),
        .chain_end (chain_tok[ROUTE_ENTRIES])
    );

    // Chain of table cells; the token moves one cell per cycle.
    for (genvar g = 0; g < ROUTE_ENTRIES; g++) begin : g_cell
        lrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .query     (query),
            .commit    (commit),
            .token_in  (chain_tok[g]),
            .token_out (chain_tok[g+1]),
            .pend      (pend_bits[g])
        );
    end

`ifndef SYNTHESIS
    // Only the first free cell of a walk may reserve itself.
    a_one_reserve: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(pend_bits))
        else $error("more than one cell reserved for a new entry");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for learning_route_table_with_aging_unit.
// A local route-table predictor checks every result; depends on lrt_pkg and the RTL.
`default_nettype none

module testbench;
    import lrt_pkg::*;

    localparam int ROUTE_SLOTS = ROUTE_ENTRIES_DEF;
    localparam int NO_SIGNAL = -256;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_PER_PHASE = 140;

    // Request codes that the block must ignore.
    localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

    typedef enum int {
        PACE_BURST,
        PACE_SPARSE,
        PACE_FULL
    } pace_t;

    typedef struct packed {
        act_t              act;
        logic [ADDR_W-1:0] hop;
        logic              valve;
        logic              conn;
        logic [ADDR_W-1:0] parent;
    } route_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [REQ_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [ACT_W-1:0] m_tuser;
    logic cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor copy of the table, the parent link and the configuration.
    logic              tbl_valid [ROUTE_SLOTS];
    logic [ID_W-1:0]   tbl_dest [ROUTE_SLOTS];
    logic [ADDR_W-1:0] tbl_hop [ROUTE_SLOTS];
    logic [AGE_W-1:0]  tbl_age [ROUTE_SLOTS];
    logic [ADDR_W-1:0] par_addr = '0;
    int                best_sig = NO_SIGNAL;
    logic              linked = 1'b0;
    logic              valve = 1'b0;
    logic [ID_W-1:0]   own_node = OWN_ID_RST;
    logic [AGE_W-1:0]  age_limit = LIMIT_RST;

    route_result_t outcome_q [$];
    pace_t src_pace = PACE_FULL;
    pace_t sink_pace = PACE_FULL;
    int sink_hold = 0;
    int faults = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int settings_used = 0;
    logic [ID_W-1:0] id_base = '0;

    learning_route_table_with_aging_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        for (int k = 0; k < ROUTE_SLOTS; k++) begin
            tbl_valid[k] = 1'b0;
        end
    end

    function automatic int draw_wait(pace_t pace);
        case (pace)
            PACE_BURST: return 0;
            PACE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    function automatic int find_route(logic [ID_W-1:0] id);
        for (int k = 0; k < ROUTE_SLOTS; k++) begin
            if (tbl_valid[k] && tbl_dest[k] == id) return k;
        end
        return -1;
    endfunction

    // Applies one request to the predictor state and returns the result it causes.
    function automatic route_result_t compute_route_outcome(
        logic [REQ_W-1:0] req, logic [ID_W-1:0] id, logic [ADDR_W-1:0] src_addr,
        logic signed [SIG_W-1:0] rssi, logic [ORDER_W-1:0] order_dig);
        route_result_t r;
        int slot;
        r.act = ACT_NONE;
        r.hop = '0;
        case (req)
            REQ_REPORT: begin
                slot = find_route(id);
                // A new source takes the lowest free entry.
                for (int k = 0; k < ROUTE_SLOTS && slot < 0; k++) begin
                    if (!tbl_valid[k]) slot = k;
                end
                if (slot < 0) begin
                    r.act = ACT_TABLE_FULL;
                end else begin
                    tbl_valid[slot] = 1'b1;
                    tbl_dest[slot] = id;
                    tbl_hop[slot] = src_addr;
                    tbl_age[slot] = '0;
                    if (src_addr[7:0] != par_addr[7:0]) begin
                        r.act = ACT_FORWARD;
                        r.hop = par_addr;
                    end
                end
            end
            REQ_COMMAND: begin
                if (id == own_node) begin
                    valve = (order_dig == ORDER_OPEN);
                    r.act = ACT_LOCAL;
                end else begin
                    slot = find_route(id);
                    if (slot < 0) begin
                        r.act = ACT_NO_ROUTE;
                    end else begin
                        r.act = ACT_FORWARD;
                        r.hop = tbl_hop[slot];
                    end
                end
            end
            REQ_AGE_TICK: begin
                for (int k = 0; k < ROUTE_SLOTS; k++) begin
                    if (tbl_valid[k]) begin
                        if (tbl_age[k] >= age_limit) tbl_valid[k] = 1'b0;
                        else tbl_age[k] = tbl_age[k] + 1'b1;
                    end
                end
            end
            REQ_PARENT_RESP: begin
                if (id == own_node && int'(rssi) > best_sig) begin
                    best_sig = int'(rssi);
                    par_addr = src_addr;
                    linked = 1'b1;
                end
            end
            REQ_ANNOUNCE: begin
                if (linked) begin
                    r.act = ACT_ANSWER;
                    r.hop = src_addr;
                end
            end
            REQ_SEND_TIMEOUT: begin
                linked = 1'b0;
                best_sig = NO_SIGNAL;
            end
            default: begin
            end
        endcase
        r.valve = valve;
        r.conn = linked;
        r.parent = par_addr;
        return r;
    endfunction

    // Sends one request transaction and records its expected result on acceptance.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
                                input logic [ADDR_W-1:0] src_addr,
                                input logic [SIG_W-1:0] rssi,
                                input logic [ORDER_W-1:0] order_dig);
        int gap;
        gap = draw_wait(src_pace);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = {4'b0, order_dig, rssi, src_addr, id};
        s_tuser = req;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        outcome_q.push_back(compute_route_outcome(req, id, src_addr, rssi, order_dig));
        requests_sent++;
    endtask

    // Stops the request stream and waits until every expected result has arrived.
    task automatic drain_pipeline();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (outcome_q.size() != 0) @(posedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        if (idx == CFG_OWN_ID) own_node = val;
        else age_limit = val[AGE_W-1:0];
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // One random request; reports target a pool of ids, and half of the commands do too.
    task automatic random_request(input int span, input int tick_pct);
        logic [REQ_W-1:0] req;
        logic [ID_W-1:0] id;
        logic [ADDR_W-1:0] src_addr;
        logic [SIG_W-1:0] rssi;
        logic [ORDER_W-1:0] order_dig;
        int pick;
        pick = $urandom_range(0, 99);
        id = $urandom;
        src_addr = $urandom;
        rssi = $urandom;
        order_dig = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
        if (pick < 40) begin
            req = REQ_REPORT;
            id = id_base + 8'($urandom_range(0, span - 1));
            if ($urandom_range(0, 4) == 0) src_addr[7:0] = par_addr[7:0];
        end else if (pick < 40 + tick_pct) begin
            req = REQ_AGE_TICK;
        end else if (pick < 52 + tick_pct) begin
            req = REQ_PARENT_RESP;
            if ($urandom_range(0, 3) != 0) id = own_node;
        end else if (pick < 60 + tick_pct) begin
            req = REQ_ANNOUNCE;
        end else if (pick < 63 + tick_pct) begin
            req = REQ_SEND_TIMEOUT;
        end else if (pick < 65 + tick_pct) begin
            req = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
        end else begin
            req = REQ_COMMAND;
            case ($urandom_range(0, 3))
                0: id = own_node;
                1: id = $urandom;
                default: id = id_base + 8'($urandom_range(0, span - 1));
            endcase
        end
        send_request(req, id, src_addr, rssi, order_dig);
    endtask

    // Result checker: compares each result transaction with the oldest expectation.
    always @(posedge aclk) begin : check_results
        route_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            sink_hold = draw_wait(sink_pace);
            if (outcome_q.size() == 0) begin
                $error("unexpected result: action %0d, tdata %h", m_tuser, m_tdata);
                faults++;
            end else begin
                want = outcome_q.pop_front();
                if (m_tuser !== want.act) begin
                    $error("action: expected %0d, got %0d", want.act, m_tuser);
                    faults++;
                end
                if (m_tdata[15:0] !== want.hop) begin
                    $error("next_hop: expected %h, got %h", want.hop, m_tdata[15:0]);
                    faults++;
                end
                if (m_tdata[16] !== want.valve) begin
                    $error("valve_open: expected %0d, got %0d", want.valve, m_tdata[16]);
                    faults++;
                end
                if (m_tdata[17] !== want.conn) begin
                    $error("connected: expected %0d, got %0d", want.conn, m_tdata[17]);
                    faults++;
                end
                if (m_tdata[33:18] !== want.parent) begin
                    $error("parent_link: expected %h, got %h", want.parent, m_tdata[33:18]);
                    faults++;
                end
            end
        end
    end

    // Receiver backpressure: after each accepted result, holds tready low while a drawn
    // hold count runs down, counting only while a result is waiting.
    always @(negedge aclk) begin
        m_tready = (sink_hold == 0);
        if (sink_hold != 0 && m_tvalid) sink_hold = sink_hold - 1;
    end

    // Watchdog on cycles in which no transaction moves on either side.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Defaults after reset and one of each request kind at field extremes.
    task automatic test_directed_cases();
        src_pace = PACE_FULL;
        sink_pace = PACE_FULL;
        send_request(REQ_ANNOUNCE, 8'h00, 16'h1234, 8'h00, 4'd0);
        send_request(REQ_COMMAND, OWN_ID_RST, 16'hFFFF, 8'hFF, ORDER_OPEN);
        send_request(REQ_COMMAND, OWN_ID_RST, 16'h0000, 8'h00, 4'd9);
        send_request(REQ_COMMAND, 8'hFF, 16'h0000, 8'h7F, ORDER_OPEN);
        // Reports while not connected still go to the parent address, unless sent from it.
        send_request(REQ_REPORT, 8'h00, 16'hFFFF, 8'h00, 4'd0);
        send_request(REQ_REPORT, 8'hFF, 16'h0100, 8'h80, 4'd15);
        send_request(REQ_COMMAND, 8'hFF, 16'h5555, 8'h00, 4'd3);
        send_request(REQ_COMMAND, 8'h00, 16'hAAAA, 8'h00, 4'd8);
        send_request(REQ_SPARE_A, 8'h5A, 16'hA5A5, 8'h5A, 4'd5);
        send_request(REQ_SPARE_B, 8'hFF, 16'hFFFF, 8'hFF, 4'd15);
        // Parent offers: another recipient, first offer, a tie, a stronger one.
        send_request(REQ_PARENT_RESP, 8'h02, 16'hBEEF, 8'h7F, 4'd0);
        send_request(REQ_PARENT_RESP, OWN_ID_RST, 16'h2A2A, 8'h80, 4'd0);
        send_request(REQ_PARENT_RESP, OWN_ID_RST, 16'h3C3C, 8'h80, 4'd0);
        send_request(REQ_PARENT_RESP, OWN_ID_RST, 16'hFF00, 8'h7F, 4'd0);
        send_request(REQ_ANNOUNCE, 8'h55, 16'hABCD, 8'h00, 4'd0);
        // A report from the parent is learned but not forwarded.
        send_request(REQ_REPORT, 8'h10, 16'h1200, 8'h00, 4'd0);
        send_request(REQ_REPORT, 8'h11, 16'h12FF, 8'h00, 4'd0);
        send_request(REQ_COMMAND, 8'h10, 16'h0000, 8'h00, 4'd15);
        send_request(REQ_SEND_TIMEOUT, 8'h00, 16'h0000, 8'h00, 4'd0);
        send_request(REQ_ANNOUNCE, 8'h55, 16'hABCD, 8'h00, 4'd0);
        send_request(REQ_PARENT_RESP, OWN_ID_RST, 16'h0001, 8'h80, 4'd0);
        send_request(REQ_AGE_TICK, 8'hC3, 16'h3CC3, 8'h3C, 4'd7);
        drain_pipeline();
    endtask

    // Fills every entry, then offers new sources to a full table.
    task automatic test_table_fill();
        logic [ID_W-1:0] base;
        src_pace = PACE_BURST;
        sink_pace = PACE_SPARSE;
        write_reg(CFG_INACTIVE_LIMIT, 8'd15);
        base = $urandom;
        for (int k = 0; k < ROUTE_SLOTS + 2; k++) begin
            send_request(REQ_REPORT, base + 8'(k), 16'($urandom), 8'($urandom), 4'd0);
        end
        send_request(REQ_REPORT, base, 16'($urandom), 8'($urandom), 4'd0);
        send_request(REQ_COMMAND, base + 8'(ROUTE_SLOTS + 1), 16'h0000, 8'h00, 4'd2);
        send_request(REQ_COMMAND, base + 8'd3, 16'h0000, 8'h00, 4'd2);
        drain_pipeline();
    endtask

    // Eviction at a limit of one and at a limit of zero.
    task automatic test_aging();
        src_pace = PACE_BURST;
        sink_pace = PACE_BURST;
        write_reg(CFG_INACTIVE_LIMIT, 8'd1);
        send_request(REQ_AGE_TICK, 8'h00, 16'h0000, 8'h00, 4'd0);
        send_request(REQ_COMMAND, 8'h11, 16'h0000, 8'h00, 4'd0);
        send_request(REQ_AGE_TICK, 8'h00, 16'h0000, 8'h00, 4'd0);
        send_request(REQ_COMMAND, 8'h11, 16'h0000, 8'h00, 4'd0);
        drain_pipeline();
        write_reg(CFG_INACTIVE_LIMIT, 8'd0);
        send_request(REQ_REPORT, 8'h42, 16'h4242, 8'h00, 4'd0);
        send_request(REQ_AGE_TICK, 8'h00, 16'h0000, 8'h00, 4'd0);
        send_request(REQ_COMMAND, 8'h42, 16'h0000, 8'h00, 4'd0);
        send_request(REQ_REPORT, 8'h43, 16'h4343, 8'h00, 4'd0);
        send_request(REQ_COMMAND, 8'h43, 16'h0000, 8'h00, 4'd0);
        drain_pipeline();
    endtask

    task automatic random_phase(input logic [ID_W-1:0] own, input logic [CFG_DATA_W-1:0] limit,
                                input int span, input int tick_pct);
        write_reg(CFG_OWN_ID, own);
        write_reg(CFG_INACTIVE_LIMIT, limit);
        settings_used++;
        id_base = $urandom;
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // Change the pacing every few dozen requests, including stretches without gaps.
            if (n % 35 == 0) begin
                src_pace = pace_t'($urandom_range(0, 2));
                sink_pace = pace_t'($urandom_range(0, 2));
            end
            random_request(span, tick_pct);
        end
        drain_pipeline();
    endtask

    // Random traffic under several register settings, extremes included.
    task automatic test_random_traffic();
        random_phase(8'h00, 8'd1, 8, 10);
        random_phase(8'hFF, 8'd15, 48, 2);
        random_phase(8'($urandom), {4'($urandom), 4'($urandom_range(1, 15))}, 40, 5);
        random_phase(OWN_ID_RST, {4'b0, LIMIT_RST}, 24, 6);
        random_phase(8'($urandom), 8'($urandom), 64, 4);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed_cases();
        test_table_fill();
        test_aging();
        test_random_traffic();
        drain_pipeline();
        repeat (ROUTE_SLOTS + 8) @(posedge aclk);
        if (outcome_q.size() != 0) begin
            $error("%0d expected results never arrived", outcome_q.size());
            faults++;
        end
        $display("Checked %0d requests and %0d results across %0d random register settings,",
                 requests_sent, results_seen, settings_used);
        $display("plus directed defaults, table-full and eviction sequences; %0d mismatches.",
                 faults);
        if (faults == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/lrt_pkg.sv
rtl/core/lrt_cell.sv
rtl/core/lrt_ctrl.sv
rtl/core/learning_route_table_with_aging_unit.sv
tb/testbench.sv
